// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CHM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/chm_pkg.sv -----
package chm_pkg;

    localparam int POOL_ENTRIES = 1024;
    localparam int MAX_BUCKETS  = 1024;
    localparam int KEY_WORDS    = 8;
    localparam int WORD_W       = 64;
    localparam int CRC_W        = 32;
    localparam int ENTRY_W      = $clog2(POOL_ENTRIES) + 1;
    localparam int EIDX_W       = $clog2(POOL_ENTRIES);
    localparam int BUCKET_W     = $clog2(MAX_BUCKETS);
    localparam int BC_W         = 11;
    localparam int KIDX_W       = $clog2(KEY_WORDS);
    localparam int KADDR_W      = EIDX_W + KIDX_W;
    localparam int DIVCNT_W     = $clog2(CRC_W);
    localparam logic [ENTRY_W-1:0] EMPTY_MARK = ENTRY_W'(POOL_ENTRIES);
    localparam logic [CRC_W-1:0]   CRC32C_POLY = 32'h82F63B78;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_GET    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FOUND = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                                cmd;
        logic [WORD_W-1:0]                   value;
        logic [KEY_WORDS-1:0][WORD_W-1:0]    key;
        logic [BUCKET_W-1:0]                 bucket;
    } op_t;

    typedef struct packed {
        logic   valid;
        status_t status;
        logic [WORD_W-1:0] prior_value;
        logic   old_valid;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] crc_in,
                                                  input logic [WORD_W-1:0] w);
        logic [CRC_W-1:0] c;
        c = crc_in;
        for (int b = 0; b < 8; b++)
        begin
            c = c ^ {24'd0, w[8*b +: 8]};
            for (int k = 0; k < 8; k++)
            begin
                c = (c >> 1) ^ (c[0] ? CRC32C_POLY : '0);
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/chm_ram.sv -----
module chm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// ----- hw/rtl/chm_front.sv -----
module chm_front import chm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           command,
    input  logic [WORD_W-1:0]    key_word,
    input  logic                 key_last,
    input  logic [WORD_W-1:0]    value,
    input  logic [BC_W-1:0]      bucket_count,
    input  logic                 back_ready,
    input  logic                 q_full,
    output logic                 q_push,
    output op_t                  q_data,
    output logic                 busy
);
    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_HASH = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t               state_reg, state_next;
    logic [KIDX_W-1:0]     wc_reg, wc_next;
    logic [KEY_WORDS-1:0]  kvalid_reg, kvalid_next;
    logic [WORD_W-1:0]     kbuf_reg [KEY_WORDS];
    logic [DIVCNT_W-1:0]   cnt_reg, cnt_next;
    logic [CRC_W-1:0]      crc_reg, crc_next;
    logic [BC_W-1:0]       rem_reg, rem_next;
    cmd_t                  cmd_reg;
    logic [WORD_W-1:0]     val_reg;
    logic                  accept;
    logic [KEY_WORDS-1:0][WORD_W-1:0] key_w;
    logic [BC_W-1:0]       rem_sh;

    assign busy   = (state_reg != F_IDLE) || !back_ready;
    assign accept = start && !busy;

    always_comb
    begin
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            key_w[i] = kvalid_reg[i] ? kbuf_reg[i] : '0;
        end
    end

    assign rem_sh = {rem_reg[BC_W-2:0], crc_reg[CRC_W-1]};
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = '{cmd: cmd_reg, value: val_reg, key: key_w,
                      bucket: rem_reg[BUCKET_W-1:0]};

    always_comb
    begin
        state_next  = state_reg;
        wc_next     = wc_reg;
        kvalid_next = kvalid_reg;
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        rem_next    = rem_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    wc_next = wc_reg + 1'b1;
                    kvalid_next[wc_reg] = 1'b1;
                    if (key_last)
                    begin
                        state_next = F_HASH;
                        cnt_next   = '0;
                        crc_next   = '0;
                    end
                end
            end
            F_HASH:
            begin
                crc_next = crc_word(crc_reg, key_w[cnt_reg[KIDX_W-1:0]]);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[KIDX_W-1:0] == KIDX_W'(KEY_WORDS - 1))
                begin
                    state_next = F_DIV;
                    cnt_next   = '0;
                    rem_next   = '0;
                end
            end
            F_DIV:
            begin
                rem_next = (rem_sh >= bucket_count) ? rem_sh - bucket_count : rem_sh;
                crc_next = {crc_reg[CRC_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIVCNT_W'(CRC_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next  = F_IDLE;
                    wc_next     = '0;
                    kvalid_next = '0;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            wc_reg     <= '0;
            kvalid_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wc_reg     <= wc_next;
            kvalid_reg <= kvalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        rem_reg <= rem_next;
        if (accept)
        begin
            kbuf_reg[wc_reg] <= key_word;
            if (key_last)
            begin
                cmd_reg <= cmd_t'(command);
                val_reg <= value;
            end
        end
    end
endmodule

// ----- hw/rtl/chm_queue.sv -----
module chm_queue import chm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    input  logic pop,
    output op_t  pop_data,
    output logic full,
    output logic empty
);
    logic [1:0] count_reg, count_next;
    logic       rd_reg, wr_reg;
    op_t        mem_reg [2];

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule

// ----- hw/rtl/chm_back.sv -----
module chm_back import chm_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  op_t     q_data,
    output logic    q_pop,
    output logic    ready,
    output result_t result
);
    typedef enum logic [9:0] {
        B_CLR  = 10'b0000000001,
        B_IDLE = 10'b0000000010,
        B_HEAD = 10'b0000000100,
        B_CHK  = 10'b0000001000,
        B_CMP  = 10'b0000010000,
        B_NXT  = 10'b0000100000,
        B_FND  = 10'b0001000000,
        B_FREE = 10'b0010000000,
        B_ALOC = 10'b0100000000,
        B_KEYW = 10'b1000000000
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [EIDX_W-1:0]    clr_reg, clr_next;
    op_t                  op_reg, op_next;
    logic [ENTRY_W-1:0]   cur_reg, cur_next;
    logic [ENTRY_W-1:0]   prev_reg, prev_next;
    logic [ENTRY_W-1:0]   head_reg, head_next;
    logic [ENTRY_W-1:0]   free_reg, free_next;
    logic [KIDX_W-1:0]    wcnt_reg, wcnt_next;
    logic                 match_reg, match_next;
    result_t              res_reg, res_next;
    logic                 m;

    logic                 keys_we, vals_we, next_we, heads_we;
    logic [KADDR_W-1:0]   keys_waddr, keys_raddr;
    logic [WORD_W-1:0]    keys_wdata, keys_rdata, vals_wdata, vals_rdata;
    logic [EIDX_W-1:0]    vals_waddr, vals_raddr, next_waddr, next_raddr;
    logic [ENTRY_W-1:0]   next_wdata, next_rdata, heads_wdata, heads_rdata;
    logic [BUCKET_W-1:0]  heads_waddr, heads_raddr;

    chm_ram #(.WIDTH(WORD_W), .DEPTH(POOL_ENTRIES * KEY_WORDS)) u_keys (
        .clk(clk), .we(keys_we), .waddr(keys_waddr), .wdata(keys_wdata),
        .raddr(keys_raddr), .rdata(keys_rdata));
    chm_ram #(.WIDTH(WORD_W), .DEPTH(POOL_ENTRIES)) u_vals (
        .clk(clk), .we(vals_we), .waddr(vals_waddr), .wdata(vals_wdata),
        .raddr(vals_raddr), .rdata(vals_rdata));
    chm_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_ENTRIES)) u_next (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(next_raddr), .rdata(next_rdata));
    chm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk(clk), .we(heads_we), .waddr(heads_waddr), .wdata(heads_wdata),
        .raddr(heads_raddr), .rdata(heads_rdata));

    assign ready  = state_reg != B_CLR;
    assign result = res_reg;
    assign m      = match_reg && (keys_rdata == op_reg.key[wcnt_reg]);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        head_next  = head_reg;
        free_next  = free_reg;
        wcnt_next  = wcnt_reg;
        match_next = match_reg;
        res_next   = '{valid: 1'b0, status: ST_OK, prior_value: '0, old_valid: 1'b0};
        q_pop      = 1'b0;
        keys_we    = 1'b0;
        keys_waddr = {cur_reg[EIDX_W-1:0], wcnt_reg};
        keys_wdata = op_reg.key[wcnt_reg];
        keys_raddr = {cur_reg[EIDX_W-1:0], KIDX_W'(0)};
        vals_we    = 1'b0;
        vals_waddr = cur_reg[EIDX_W-1:0];
        vals_wdata = op_reg.value;
        vals_raddr = cur_reg[EIDX_W-1:0];
        next_we    = 1'b0;
        next_waddr = cur_reg[EIDX_W-1:0];
        next_wdata = free_reg;
        next_raddr = cur_reg[EIDX_W-1:0];
        heads_we    = 1'b0;
        heads_waddr = op_reg.bucket;
        heads_wdata = next_rdata;
        heads_raddr = q_data.bucket;
        unique case (state_reg)
            B_CLR:
            begin
                heads_we    = 1'b1;
                heads_waddr = BUCKET_W'(clr_reg);
                heads_wdata = EMPTY_MARK;
                next_we     = 1'b1;
                next_waddr  = clr_reg;
                next_wdata  = ENTRY_W'(clr_reg) + 1'b1;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == EIDX_W'(POOL_ENTRIES - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_data;
                    state_next = B_HEAD;
                end
            end
            B_HEAD:
            begin
                head_next  = heads_rdata;
                cur_next   = heads_rdata;
                prev_next  = EMPTY_MARK;
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (cur_reg == EMPTY_MARK)
                begin
                    if (op_reg.cmd == CMD_INSERT && free_reg != EMPTY_MARK)
                    begin
                        next_raddr = free_reg[EIDX_W-1:0];
                        cur_next   = free_reg;
                        state_next = B_ALOC;
                    end
                    else
                    begin
                        res_next.valid  = 1'b1;
                        res_next.status = (op_reg.cmd == CMD_INSERT) ? ST_FULL : ST_OK;
                        state_next      = B_IDLE;
                    end
                end
                else
                begin
                    wcnt_next  = '0;
                    match_next = 1'b1;
                    state_next = B_CMP;
                end
            end
            B_CMP:
            begin
                if (wcnt_reg == KIDX_W'(KEY_WORDS - 1))
                begin
                    state_next = m ? B_FND : B_NXT;
                end
                else
                begin
                    keys_raddr = {cur_reg[EIDX_W-1:0], wcnt_reg + 1'b1};
                    wcnt_next  = wcnt_reg + 1'b1;
                    match_next = m;
                end
            end
            B_NXT:
            begin
                prev_next  = cur_reg;
                cur_next   = next_rdata;
                state_next = B_CHK;
            end
            B_FND:
            begin
                res_next.valid = 1'b1;
                state_next     = B_IDLE;
                if (op_reg.cmd != CMD_NONE)
                begin
                    res_next.status      = ST_FOUND;
                    res_next.prior_value = vals_rdata;
                    res_next.old_valid   = 1'b1;
                end
                case (op_reg.cmd)
                    CMD_INSERT: vals_we = 1'b1;
                    CMD_ERASE:
                    begin
                        state_next = B_FREE;
                        if (prev_reg != EMPTY_MARK)
                        begin
                            next_we    = 1'b1;
                            next_waddr = prev_reg[EIDX_W-1:0];
                            next_wdata = next_rdata;
                        end
                        else
                        begin
                            heads_we = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            B_FREE:
            begin
                next_we    = 1'b1;
                free_next  = cur_reg;
                state_next = B_IDLE;
            end
            B_ALOC:
            begin
                free_next      = next_rdata;
                vals_we        = 1'b1;
                next_we        = 1'b1;
                next_wdata     = head_reg;
                heads_we       = 1'b1;
                heads_wdata    = cur_reg;
                wcnt_next      = '0;
                res_next.valid = 1'b1;
                state_next     = B_KEYW;
            end
            B_KEYW:
            begin
                keys_we   = 1'b1;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == KIDX_W'(KEY_WORDS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLR;
            clr_reg   <= '0;
            free_reg  <= '0;
            res_reg   <= '{valid: 1'b0, status: ST_OK, prior_value: '0, old_valid: 1'b0};
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        head_reg  <= head_next;
        wcnt_reg  <= wcnt_next;
        match_reg <= match_next;
    end
endmodule

// ----- hw/rtl/chained_hash_map_engine.sv -----
// Key-value map over 64-byte keys, separate chaining, CRC32C bucket hash.
// A key enters as up to eight 64-bit words, one per cycle while busy is
// low, with missing words read as zero; the word with key_last carries
// command and value and starts the operation. The front hashes the key
// word by word, reduces it modulo bucket_count with a serial divider and
// hands it to a 2-deep queue, so busy stays high from the last word until
// the push and longer while the queue is full. The back walks the bucket
// chain, one key word compared per cycle from the key memory for each
// entry visited, plus a setup state that reads the bucket head, a state
// to free the entry on erase, and states that link and write the key on
// insert of a new entry. One result strobe per operation; the receiver
// cannot stall it. After reset a clearing pass over all 1024 pool entries
// builds the free list and empties the buckets, with busy held high.
module chained_hash_map_engine import chm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [WORD_W-1:0] key_word,
    input  logic              key_last,
    input  logic [WORD_W-1:0] value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BC_W-1:0]   cfg_data,
    output logic              result_valid,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] prior_value,
    output logic              old_valid
);
    logic [BC_W-1:0] bucket_count_reg;
    logic            q_push, q_pop, q_full, q_empty, back_ready;
    op_t             q_in, q_out;
    result_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BC_W'(MAX_BUCKETS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data == '0)
            begin
                bucket_count_reg <= BC_W'(1);
            end
            else if (cfg_data > BC_W'(MAX_BUCKETS))
            begin
                bucket_count_reg <= BC_W'(MAX_BUCKETS);
            end
            else
            begin
                bucket_count_reg <= cfg_data;
            end
        end
    end

    chm_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .key_word(key_word), .key_last(key_last), .value(value),
        .bucket_count(bucket_count_reg), .back_ready(back_ready),
        .q_full(q_full), .q_push(q_push), .q_data(q_in), .busy(busy));

    chm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in),
        .pop(q_pop), .pop_data(q_out), .full(q_full), .empty(q_empty));

    chm_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_out),
        .q_pop(q_pop), .ready(back_ready), .result(res));

    assign result_valid = res.valid;
    assign status       = res.status;
    assign prior_value  = res.prior_value;
    assign old_valid    = res.old_valid;
endmodule

// ----- hw/rtl/chm_checker.sv -----
`include "assert_macros.svh"

module chm_checker import chm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              key_last,
    input logic              result_valid,
    input logic [1:0]        status,
    input logic [WORD_W-1:0] prior_value,
    input logic              old_valid
);
    `CHM_ASSERT(a_status_code, clk, rst_n, result_valid |-> status <= ST_FULL, "bad status code")
    `CHM_ASSERT(a_found, clk, rst_n, result_valid |-> old_valid == (status == ST_FOUND), "old_valid")
    `CHM_ASSERT(a_zero, clk, rst_n, (result_valid && !old_valid) |-> prior_value == '0, "nonzero")
    `CHM_ASSERT(a_busy_after_last, clk, rst_n, (start && !busy && key_last) |=> busy, "not busy")
    `CHM_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !result_valid, "result during reset")
endmodule

bind chained_hash_map_engine chm_checker u_chm_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .key_last(key_last),
    .result_valid(result_valid), .status(status), .prior_value(prior_value),
    .old_valid(old_valid));
